@@ hw/rtl/dq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the deque unit.
package dq_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int VAL_W     = 32;
	localparam int FILL_W    = 7;

	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_POP_FRONT  = 2'd1,
		KIND_PUSH_BACK  = 2'd2,
		KIND_POP_BACK   = 2'd3
	} dq_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} dq_status_t;

	typedef struct packed {
		logic       exec;
		logic       is_push;
		logic       at_front;
		dq_status_t code;
	} dq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dq_flags_t;

endpackage

@@ hw/rtl/double_ended_queue_unit.sv @@
// Top level of the double-ended queue unit built on a ring store.
// Latency: a result strobes on done in the cycle after the transfer on start.
// A new operation is accepted only while idle; busy stays high for the result cycle.
// Reset: arst_n clears the indices, the count and the controller; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue_unit
	import dq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic signed [VAL_W-1:0] push_value,
	output logic                    done,
	output logic signed [VAL_W-1:0] pop_value,
	output logic [1:0]              status,
	output logic [FILL_W-1:0]       fill_count
);

	dq_cmd_t   cmd;
	dq_flags_t flags;

	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (push_value),
		.flags      (flags),
		.pop_value  (pop_value),
		.status     (status),
		.fill_count (fill_count)
	);

endmodule

@@ hw/rtl/dq_ctrl.sv @@
// Controller state machine that accepts operations and sequences the result strobe.
module dq_ctrl
	import dq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  dq_flags_t  flags,
	output dq_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;
	logic   is_push;

	assign accept  = start && (state_q == S_IDLE);
	assign is_push = kind inside {KIND_PUSH_FRONT, KIND_PUSH_BACK};

	always_comb begin
		cmd.exec     = accept;
		cmd.is_push  = is_push;
		cmd.at_front = kind inside {KIND_PUSH_FRONT, KIND_POP_FRONT};
		if (is_push) begin
			cmd.code = flags.full ? ST_FULL : ST_OK;
		end else begin
			cmd.code = flags.empty ? ST_EMPTY : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
						busy_q  <= 1'b1;
						done_q  <= 1'b1;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ hw/rtl/dq_datapath.sv @@
// Datapath with the ring store, the front and back indices and the occupancy count.
module dq_datapath
	import dq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  dq_cmd_t                 cmd,
	input  logic signed [VAL_W-1:0] push_value,
	output dq_flags_t               flags,
	output logic signed [VAL_W-1:0] pop_value,
	output logic [1:0]              status,
	output logic [FILL_W-1:0]       fill_count
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic [IDX_W-1:0]     front_q;
	logic [IDX_W-1:0]     back_q;
	logic [CNT_W-1:0]     occ_q;
	dq_status_t           code_q;
	logic                 pop_ok_q;

	logic [IDX_W-1:0] front_dn;
	logic [IDX_W-1:0] front_up;
	logic [IDX_W-1:0] back_dn;
	logic [IDX_W-1:0] back_up;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic             op_ok;
	logic             wr_en;
	logic             rd_en;

	assign front_dn = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_up = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign back_dn  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;
	assign back_up  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;

	assign op_ok   = cmd.exec && (cmd.code == ST_OK);
	assign wr_en   = op_ok && cmd.is_push;
	assign rd_en   = op_ok && !cmd.is_push;
	assign wr_addr = cmd.at_front ? front_dn : back_q;
	assign rd_addr = cmd.at_front ? front_q : back_dn;

	assign flags.full  = (occ_q >= CNT_W'(DEPTH));
	assign flags.empty = (occ_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= WORD_BITS'($unsigned(push_value));
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			occ_q    <= '0;
			code_q   <= ST_OK;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			code_q   <= cmd.code;
			pop_ok_q <= rd_en;
			if (wr_en) begin
				occ_q <= occ_q + 1'b1;
				if (cmd.at_front) begin
					front_q <= front_dn;
				end else begin
					back_q <= back_up;
				end
			end else if (rd_en) begin
				occ_q <= occ_q - 1'b1;
				if (cmd.at_front) begin
					front_q <= front_up;
				end else begin
					back_q <= back_dn;
				end
			end
		end
	end

	always_comb begin
		if (code_q == ST_EMPTY) begin
			pop_value = '1;
		end else if (pop_ok_q) begin
			pop_value = VAL_W'($signed(rdata_q));
		end else begin
			pop_value = '0;
		end
	end

	assign status     = code_q;
	assign fill_count = FILL_W'(occ_q);

endmodule

@@ hw/rtl/dq_checker.sv @@
// Port-level checker for the deque unit and its bind to the top level.
module dq_checker
	import dq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic signed [VAL_W-1:0] pop_value,
	input logic [1:0]              status,
	input logic [FILL_W-1:0]       fill_count
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("Transfer on start was not followed by a result.");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result strobe outside an operation.");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |-> (pop_value == -1) && (fill_count == '0))
		else $error("Empty pop did not return -1 with a zero count.");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> (pop_value == '0) && (fill_count == FILL_W'(DEPTH)))
		else $error("Refused push did not report a full queue.");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.pop_value  (pop_value),
	.status     (status),
	.fill_count (fill_count)
);
